FILE: rtl/bgra_to_yuv420_converter_core_defines.svh
// assertion macros for the bgra to yuv 4:2:0 converter checker
`ifndef BGRA_TO_YUV420_CONVERTER_CORE_DEFINES_SVH
`define BGRA_TO_YUV420_CONVERTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on i_clk and quiet while i_rst_n is low
`define B2Y_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk and quiet while i_rst_n is low
`define B2Y_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/b2y420_pkg.sv
// shared types, constants and functions of the bgra to yuv 4:2:0 converter
`timescale 1ns / 1ps
`default_nettype none

package b2y420_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int WSIZE_W   = COL_W + 1;
    localparam int HSIZE_W   = ROW_W + 1;
    localparam int SLOT_W    = COL_W - 1;
    localparam int LS_DEPTH  = MAX_WIDTH / 2;
    localparam int LS_DATA_W = 18;
    localparam int CFG_W     = 13;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_CHROMA_LAYOUT = 2'd2;

    localparam logic LAYOUT_NV12 = 1'b0;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1920;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1080;

    // bt.601 limited range coefficients, bias includes rounding
    localparam int Y_R = 66;
    localparam int Y_G = 129;
    localparam int Y_B = 25;
    localparam int Y_BIAS = 128;
    localparam int U_R = -38;
    localparam int U_G = -74;
    localparam int U_B = 112;
    localparam int V_R = 112;
    localparam int V_G = -94;
    localparam int V_B = -18;
    localparam int UV_BIAS = 128 + (128 << 8);
    localparam logic [7:0] Y_OFFSET = 8'd16;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0]  luma;
        logic [11:0] luma_column;
        logic [11:0] luma_row;
        logic        chroma_valid;
        logic [7:0]  chroma_u;
        logic [7:0]  chroma_v;
        logic [10:0] chroma_row;
        logic [11:0] u_index;
        logic [11:0] v_index;
        logic        frame_done;
    } t_pix_out;

    typedef struct packed {
        logic                 en;
        logic [SLOT_W-1:0]    addr;
        logic [LS_DATA_W-1:0] data;
    } t_ls_wr;

    // weighted sum of one pixel; every coefficient set keeps it inside 0..65535
    function automatic logic [15:0] csc_sum(input int kr, input int kg, input int kb,
                                            input int bias, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b);
        int acc;
        acc = kr * int'(r) + kg * int'(g) + kb * int'(b) + bias;
        return 16'(acc);
    endfunction

    // even size, zero taken as two, clipped to the bound
    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                  input int bound);
        logic [CFG_W-1:0] s;
        s = v & ~CFG_W'(1);
        if (s == '0) begin
            s = CFG_W'(2);
        end else if (int'(s) > bound) begin
            s = CFG_W'(bound) & ~CFG_W'(1);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bgra_to_yuv420_converter_core.sv
// Converts a raster stream of BGRA pixels to BT.601 limited-range YUV 4:2:0 at one pixel
// per clock while input is not held off. Each accepted pixel gives one result: a request is taken
// into the colour stage, the weighted sums are registered, and the chroma stage reads the
// pair entry of the line store (synchronous read) before the output register.
// The line store holds 2048 entries and is written by the even row before the odd row
// reads it, so it needs no clearing after reset. Input is held off only while the output
// register is full and stalled and every stage behind it is occupied.
`timescale 1ns / 1ps
`default_nettype none

module bgra_to_yuv420_converter_core
    import b2y420_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_pix_in          i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_pix_out              o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    // configuration, held as effective sizes
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             r_layout;

    // position counters
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // stage 1: pixel and position
    logic             r_s1_valid;
    logic [7:0]       r_s1_red, r_s1_green, r_s1_blue;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_done;

    // stage 2: per pixel y, u, v
    logic             r_s2_valid;
    logic [7:0]       r_s2_y, r_s2_u, r_s2_v;
    logic [COL_W-1:0] r_s2_col;
    logic [ROW_W-1:0] r_s2_row;
    logic             r_s2_done;

    logic [7:0]       r_left_u, r_left_v;

    logic             r_out_valid;
    t_pix_out         r_out, n_out;

    logic out_ready, s2_ready, s1_ready, in_accept, s1_move, s2_move;

    logic [COL_W-1:0]   col_in, col_cur;
    logic [ROW_W-1:0]   row_in, row_cur;
    logic               col_wrap;
    logic [HSIZE_W-1:0] row_inc, row_nxt;
    logic [WSIZE_W-1:0] col_nxt;
    logic               pix_done;

    logic [15:0] y_sum, u_sum, v_sum;

    logic [LS_DATA_W-1:0] ls_rd_data;
    t_ls_wr               ls_wr;
    logic [8:0]           pair_u, pair_v;
    logic [9:0]           blk_u, blk_v;

    // ---------------- handshake ----------------
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s2_ready   = !r_s2_valid || out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_ready;
    assign in_accept  = i_in_valid && s1_ready;
    assign s1_move    = r_s1_valid && s2_ready;
    assign s2_move    = r_s2_valid && out_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= eff_size(WIDTH_RESET, MAX_WIDTH);
            r_height <= eff_size(HEIGHT_RESET, MAX_HEIGHT);
            r_layout <= LAYOUT_NV12;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAME_WIDTH: begin
                    r_width <= eff_size(i_cfg_wdata, MAX_WIDTH);
                end
                CFG_FRAME_HEIGHT: begin
                    r_height <= eff_size(i_cfg_wdata, MAX_HEIGHT);
                end
                CFG_CHROMA_LAYOUT: begin
                    r_layout <= i_cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- position of the incoming pixel ----------------
    always_comb begin
        col_in   = i_in_data.frame_start ? '0 : r_col;
        row_in   = i_in_data.frame_start ? '0 : r_row;
        // a position left past the size by a register write wraps to the next row
        col_wrap = {1'b0, col_in} >= r_width;
        col_cur  = col_wrap ? '0 : col_in;
        row_inc  = col_wrap ? {1'b0, row_in} + HSIZE_W'(1) : {1'b0, row_in};
        row_cur  = (row_inc >= r_height) ? '0 : row_inc[ROW_W-1:0];
        pix_done = ({1'b0, col_cur} == r_width - WSIZE_W'(1))
                && ({1'b0, row_cur} == r_height - HSIZE_W'(1));

        col_nxt = {1'b0, col_cur} + WSIZE_W'(1);
        row_nxt = {1'b0, row_cur} + HSIZE_W'(1);
        if (col_nxt >= r_width) begin
            n_col = '0;
            n_row = (row_nxt >= r_height) ? '0 : row_nxt[ROW_W-1:0];
        end else begin
            n_col = col_nxt[COL_W-1:0];
            n_row = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_red   <= i_in_data.red;
            r_s1_green <= i_in_data.green;
            r_s1_blue  <= i_in_data.blue;
            r_s1_col   <= col_cur;
            r_s1_row   <= row_cur;
            r_s1_done  <= pix_done;
        end
    end

    assign y_sum = csc_sum(Y_R, Y_G, Y_B, Y_BIAS, r_s1_red, r_s1_green, r_s1_blue);
    assign u_sum = csc_sum(U_R, U_G, U_B, UV_BIAS, r_s1_red, r_s1_green, r_s1_blue);
    assign v_sum = csc_sum(V_R, V_G, V_B, UV_BIAS, r_s1_red, r_s1_green, r_s1_blue);

    // ---------------- stage 2 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // sums never leave 0..65535, so no clamp is needed after the shift
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_y   <= y_sum[15:8] + Y_OFFSET;
            r_s2_u   <= u_sum[15:8];
            r_s2_v   <= v_sum[15:8];
            r_s2_col <= r_s1_col;
            r_s2_row <= r_s1_row;
            r_s2_done <= r_s1_done;
        end
    end

    // pair entry is read as the pixel enters stage 2, written as the pixel leaves it
    b2y420_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (s1_move),
        .i_rd_addr (r_s1_col[COL_W-1:1]),
        .i_wr      (ls_wr),
        .o_rd_data (ls_rd_data)
    );

    always_comb begin
        pair_u = {1'b0, r_left_u} + {1'b0, r_s2_u};
        pair_v = {1'b0, r_left_v} + {1'b0, r_s2_v};
        blk_u  = {1'b0, ls_rd_data[8:0]} + {2'b0, r_left_u} + {2'b0, r_s2_u} + 10'd2;
        blk_v  = {1'b0, ls_rd_data[17:9]} + {2'b0, r_left_v} + {2'b0, r_s2_v} + 10'd2;

        ls_wr.en   = s2_move && r_s2_col[0] && !r_s2_row[0];
        ls_wr.addr = r_s2_col[COL_W-1:1];
        ls_wr.data = {pair_v, pair_u};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_u <= '0;
            r_left_v <= '0;
        end else if (s2_move && !r_s2_col[0]) begin
            r_left_u <= r_s2_u;
            r_left_v <= r_s2_v;
        end
    end

    always_comb begin
        n_out              = '0;
        n_out.luma         = r_s2_y;
        n_out.luma_column  = r_s2_col;
        n_out.luma_row     = r_s2_row;
        n_out.frame_done   = r_s2_done;
        if (r_s2_col[0] && r_s2_row[0]) begin
            n_out.chroma_valid = 1'b1;
            n_out.chroma_u     = blk_u[9:2];
            n_out.chroma_v     = blk_v[9:2];
            n_out.chroma_row   = r_s2_row[ROW_W-1:1];
            if (r_layout == LAYOUT_NV12) begin
                n_out.u_index = r_s2_col - 12'd1;
                n_out.v_index = r_s2_col;
            end else begin
                n_out.u_index = {1'b0, r_s2_col[COL_W-1:1]};
                n_out.v_index = {1'b0, r_s2_col[COL_W-1:1]};
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/b2y420_line_store.sv
// line store of summed chroma per pixel pair of the even row
`timescale 1ns / 1ps
`default_nettype none

module b2y420_line_store
    import b2y420_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rd_en,
    input  wire logic [SLOT_W-1:0]    i_rd_addr,
    input  wire t_ls_wr               i_wr,
    output logic      [LS_DATA_W-1:0] o_rd_data
);

    logic [LS_DATA_W-1:0] r_mem [LS_DEPTH];
    logic [LS_DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/b2y420_checker.sv
// port-level checker of the bgra to yuv 4:2:0 converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "bgra_to_yuv420_converter_core_defines.svh"

module b2y420_checker
    import b2y420_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_out_valid,
    input wire logic             i_out_stall,
    input wire t_pix_out         o_out_data
);

    // a stalled result keeps its contents
    `B2Y_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // chroma only closes a 2x2 block, at the odd column of an odd row
    `B2Y_ASSERT_IMP(a_chroma_pos, o_out_valid && o_out_data.chroma_valid, o_out_data.luma_column[0] && o_out_data.luma_row[0] && (o_out_data.chroma_row == o_out_data.luma_row[11:1]), "chroma at wrong position")

    // chroma fields read zero without chroma
    `B2Y_ASSERT_IMP(a_chroma_zero, o_out_valid && !o_out_data.chroma_valid, (o_out_data.chroma_u == 8'd0) && (o_out_data.chroma_v == 8'd0) && (o_out_data.chroma_row == 11'd0) && (o_out_data.u_index == 12'd0) && (o_out_data.v_index == 12'd0), "chroma fields not cleared")

    // sizes are even, so the last pixel always closes a block
    `B2Y_ASSERT_IMP(a_done_block, o_out_valid && o_out_data.frame_done, o_out_data.chroma_valid, "frame end without chroma")

    // indices follow one of the two layouts
    `B2Y_ASSERT_IMP(a_index_form, o_out_valid && o_out_data.chroma_valid, ((o_out_data.v_index == o_out_data.luma_column) && (o_out_data.u_index == o_out_data.luma_column - 12'd1)) || ((o_out_data.u_index == {1'b0, o_out_data.luma_column[11:1]}) && (o_out_data.v_index == o_out_data.u_index)), "chroma index mismatch")

endmodule

bind bgra_to_yuv420_converter_core b2y420_checker u_b2y420_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
